FILE: src/assert_macros.svh
// Assertion macros for the grid occupancy RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define CHECK_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("check failed");

// Check a property on every rising clock edge, reset included.
`define CHECK_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("check failed");

`endif

FILE: src/gfo_pkg.sv
// Shared types, constants and helpers for the grid occupancy block.
// Depends on nothing; used by the controller, the datapath and the top level.
package gfo_pkg;

   localparam int MAX_COLS = 64;
   localparam int MAX_ROWS = 64;
   localparam int COL_W    = $clog2(MAX_COLS);
   localparam int ROW_W    = $clog2(MAX_ROWS);
   localparam int ADDR_W   = COL_W + ROW_W;
   localparam int DIM_W    = 7;
   localparam int OP_W     = 4;

   localparam logic [DIM_W-1:0] MAX_COLS_V = DIM_W'(MAX_COLS);
   localparam logic [DIM_W-1:0] MAX_ROWS_V = DIM_W'(MAX_ROWS);

   localparam logic [OP_W-1:0] OP_CAN_PLACE     = 4'd0;
   localparam logic [OP_W-1:0] OP_PLACE         = 4'd1;
   localparam logic [OP_W-1:0] OP_REMOVE        = 4'd2;
   localparam logic [OP_W-1:0] OP_SET_BLOCKED   = 4'd3;
   localparam logic [OP_W-1:0] OP_CLR_BLOCKED   = 4'd4;
   localparam logic [OP_W-1:0] OP_SET_OCCUPIED  = 4'd5;
   localparam logic [OP_W-1:0] OP_CLR_OCCUPIED  = 4'd6;
   localparam logic [OP_W-1:0] OP_QUERY         = 4'd7;
   localparam logic [OP_W-1:0] OP_CLR_PLACEMENT = 4'd8;

   localparam logic CSR_GRID_COLS = 1'b0;
   localparam logic CSR_GRID_ROWS = 1'b1;

   // bit 0 blocked, bit 1 occupied
   typedef logic [1:0] marks_type;
   localparam marks_type MARK_BLOCKED  = 2'b01;
   localparam marks_type MARK_OCCUPIED = 2'b10;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DECIDE, ST_CHK_RD, ST_CHK_EV, ST_MRK_RD, ST_MRK_WR,
      ST_CEL_RD, ST_CEL_WR, ST_SWP_RD, ST_SWP_WR, ST_CLR,
      ST_FIN_RD, ST_FIN_EV, ST_RESP
   } state_type;

   typedef enum logic [1:0] {ADDR_CURSOR, ADDR_START, ADDR_SWEEP} addr_sel_type;
   typedef enum logic [1:0] {WR_ZERO, WR_APPLY, WR_DROP_OCC} wr_kind_type;

   typedef struct packed {
      logic         load;
      logic         mem_rd;
      logic         mem_wr;
      addr_sel_type addr_sel;
      wr_kind_type  wr_kind;
      logic         cur_clear;
      logic         cur_step;
      logic         swp_clear;
      logic         swp_step;
      logic         ok_set;
      logic         capture;
      logic         rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            rect_ok;
      logic            in_grid;
      logic            cur_last;
      logic            swp_last;
      logic            rd_nonzero;
      logic            rd_blocked;
      logic            rsp_free;
   } status_type;

   function automatic marks_type apply_op(input logic [OP_W-1:0] op, input marks_type m);
      marks_type r;
      r = m;
      case (op)
         OP_PLACE, OP_SET_OCCUPIED: r = m | MARK_OCCUPIED;
         OP_REMOVE, OP_CLR_OCCUPIED: r = m & MARK_BLOCKED;
         OP_SET_BLOCKED: r = m | MARK_BLOCKED;
         OP_CLR_BLOCKED: r = m & MARK_OCCUPIED;
         default: r = m;
      endcase
      return r;
   endfunction

endpackage

FILE: src/gfo_datapath.sv
// Datapath: request and grid registers, cell store, rectangle cursor and result register.
// Depends on gfo_pkg; driven by gfo_controller through cmd_type.
module gfo_datapath
   import gfo_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output status_type           sts,
   input  logic [OP_W-1:0]      req_op,
   input  logic [COL_W-1:0]     req_start_col,
   input  logic [ROW_W-1:0]     req_start_row,
   input  logic [DIM_W-1:0]     req_span_cols,
   input  logic [DIM_W-1:0]     req_span_rows,
   input  logic                 csr_we,
   input  logic                 csr_index,
   input  logic [DIM_W-1:0]     csr_wdata,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_ok,
   output logic                 rsp_cell_blocked,
   output logic                 rsp_cell_occupied,
   output logic                 rsp_cell_available
);

   marks_type cells [2**ADDR_W];

   logic [DIM_W-1:0]  cols_ff, rows_ff;
   logic [OP_W-1:0]   op_ff;
   logic [COL_W-1:0]  col_ff;
   logic [ROW_W-1:0]  row_ff;
   logic [DIM_W-1:0]  span_c_ff, span_r_ff;
   logic [COL_W-1:0]  x_ff, x_in;
   logic [ROW_W-1:0]  y_ff, y_in;
   logic [ADDR_W-1:0] swp_ff, swp_in;
   marks_type         rdata_ff, marks_ff, wdata;
   logic              ok_ff, ok_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_ok_ff;
   marks_type         rsp_marks_ff;
   logic              rsp_avail_ff;
   logic [DIM_W-1:0]  used_c, used_r;
   logic              in_grid, rect_ok, x_last, y_last;
   logic [ADDR_W-1:0] addr;
   logic [COL_W-1:0]  cur_col;
   logic [ROW_W-1:0]  cur_row;

   assign used_c  = (cols_ff > MAX_COLS_V) ? MAX_COLS_V : cols_ff;
   assign used_r  = (rows_ff > MAX_ROWS_V) ? MAX_ROWS_V : rows_ff;
   assign in_grid = ({1'b0, col_ff} < used_c) && ({1'b0, row_ff} < used_r);
   assign rect_ok = in_grid && (span_c_ff != '0) && (span_r_ff != '0)
                    && (span_c_ff <= used_c - {1'b0, col_ff})
                    && (span_r_ff <= used_r - {1'b0, row_ff});
   assign x_last  = ({1'b0, x_ff} == span_c_ff - DIM_W'(1));
   assign y_last  = ({1'b0, y_ff} == span_r_ff - DIM_W'(1));
   assign cur_col = col_ff + x_ff;
   assign cur_row = row_ff + y_ff;

   always_comb begin
      case (cmd.addr_sel)
         ADDR_CURSOR: addr = {cur_row, cur_col};
         ADDR_START:  addr = {row_ff, col_ff};
         ADDR_SWEEP:  addr = swp_ff;
         default:     addr = swp_ff;
      endcase
      case (cmd.wr_kind)
         WR_APPLY:    wdata = apply_op(op_ff, rdata_ff);
         WR_DROP_OCC: wdata = rdata_ff & MARK_BLOCKED;
         default:     wdata = '0;
      endcase
   end

   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      if (cmd.cur_clear) begin
         x_in = '0;
         y_in = '0;
      end else if (cmd.cur_step) begin
         if (x_last) begin
            x_in = '0;
            y_in = y_ff + ROW_W'(1);
         end else begin
            x_in = x_ff + COL_W'(1);
         end
      end
      swp_in = cmd.swp_clear ? '0 : (cmd.swp_step ? swp_ff + ADDR_W'(1) : swp_ff);
      ok_in  = cmd.load ? 1'b0 : (cmd.ok_set ? 1'b1 : ok_ff);
      rsp_valid_in = cmd.rsp_load ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_wr) begin
         cells[addr] <= wdata;
      end
      if (cmd.mem_rd) begin
         rdata_ff <= cells[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff      <= MAX_COLS_V;
         rows_ff      <= MAX_ROWS_V;
         swp_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we && csr_index == CSR_GRID_COLS) cols_ff <= csr_wdata;
         if (csr_we && csr_index == CSR_GRID_ROWS) rows_ff <= csr_wdata;
         swp_ff       <= swp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= req_op;
         col_ff    <= req_start_col;
         row_ff    <= req_start_row;
         span_c_ff <= req_span_cols;
         span_r_ff <= req_span_rows;
      end
      x_ff  <= x_in;
      y_ff  <= y_in;
      ok_ff <= ok_in;
      if (cmd.capture) begin
         marks_ff <= in_grid ? rdata_ff : '0;
      end
      if (cmd.rsp_load) begin
         rsp_ok_ff    <= ok_ff;
         rsp_marks_ff <= marks_ff;
         rsp_avail_ff <= in_grid && (marks_ff == '0);
      end
   end

   assign sts.op         = op_ff;
   assign sts.rect_ok    = rect_ok;
   assign sts.in_grid    = in_grid;
   assign sts.cur_last   = x_last && y_last;
   assign sts.swp_last   = &swp_ff;
   assign sts.rd_nonzero = rdata_ff != '0;
   assign sts.rd_blocked = rdata_ff[0];
   assign sts.rsp_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_ok             = rsp_ok_ff;
   assign rsp_cell_blocked   = rsp_marks_ff[0];
   assign rsp_cell_occupied  = rsp_marks_ff[1];
   assign rsp_cell_available = rsp_avail_ff;

endmodule

FILE: src/gfo_controller.sv
// Controller state machine: sequences rectangle walks, cell updates and store sweeps.
// Depends on gfo_pkg and assert_macros.svh; commands gfo_datapath.
`include "assert_macros.svh"
module gfo_controller
   import gfo_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       csr_we,
   input  status_type sts,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      accept;

   assign req_stall = (state_ff != ST_IDLE) || csr_we;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (csr_we) state_in = ST_CLR;
            else if (accept) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            case (sts.op)
               OP_CAN_PLACE, OP_PLACE: state_in = sts.rect_ok ? ST_CHK_RD : ST_FIN_RD;
               OP_REMOVE: state_in = sts.rect_ok ? ST_MRK_RD : ST_FIN_RD;
               OP_SET_BLOCKED, OP_CLR_BLOCKED, OP_SET_OCCUPIED, OP_CLR_OCCUPIED:
                  state_in = sts.in_grid ? ST_CEL_RD : ST_FIN_RD;
               OP_CLR_PLACEMENT: state_in = ST_SWP_RD;
               default: state_in = ST_FIN_RD;
            endcase
         end
         ST_CHK_RD: state_in = ST_CHK_EV;
         ST_CHK_EV: begin
            if (sts.rd_nonzero) state_in = ST_FIN_RD;
            else if (!sts.cur_last) state_in = ST_CHK_RD;
            else if (sts.op == OP_PLACE) state_in = ST_MRK_RD;
            else state_in = ST_FIN_RD;
         end
         ST_MRK_RD: state_in = ST_MRK_WR;
         ST_MRK_WR: state_in = sts.cur_last ? ST_FIN_RD : ST_MRK_RD;
         ST_CEL_RD: state_in = ST_CEL_WR;
         ST_CEL_WR: state_in = ST_FIN_RD;
         ST_SWP_RD: state_in = ST_SWP_WR;
         ST_SWP_WR: state_in = sts.swp_last ? ST_FIN_RD : ST_SWP_RD;
         ST_CLR:    state_in = sts.swp_last ? ST_IDLE : ST_CLR;
         ST_FIN_RD: state_in = ST_FIN_EV;
         ST_FIN_EV: state_in = ST_RESP;
         ST_RESP:   state_in = sts.rsp_free ? ST_IDLE : ST_RESP;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.addr_sel = ADDR_START;
      cmd.wr_kind  = WR_ZERO;
      case (state_ff)
         ST_IDLE: begin
            cmd.load      = accept;
            cmd.swp_clear = csr_we;
         end
         ST_DECIDE: begin
            case (sts.op)
               OP_CAN_PLACE, OP_PLACE: cmd.cur_clear = 1'b1;
               OP_REMOVE: begin
                  cmd.cur_clear = 1'b1;
                  cmd.ok_set    = sts.rect_ok;
               end
               OP_QUERY: cmd.ok_set = sts.in_grid;
               OP_CLR_PLACEMENT: begin
                  cmd.swp_clear = 1'b1;
                  cmd.ok_set    = 1'b1;
               end
               default: cmd.cur_clear = 1'b0;
            endcase
         end
         ST_CHK_RD: begin
            cmd.mem_rd   = 1'b1;
            cmd.addr_sel = ADDR_CURSOR;
         end
         ST_CHK_EV: begin
            if (!sts.rd_nonzero) begin
               if (sts.cur_last) begin
                  cmd.cur_clear = 1'b1;
                  cmd.ok_set    = 1'b1;
               end else begin
                  cmd.cur_step = 1'b1;
               end
            end
         end
         ST_MRK_RD: begin
            cmd.mem_rd   = 1'b1;
            cmd.addr_sel = ADDR_CURSOR;
         end
         ST_MRK_WR: begin
            cmd.mem_wr   = 1'b1;
            cmd.addr_sel = ADDR_CURSOR;
            cmd.wr_kind  = WR_APPLY;
            cmd.cur_step = 1'b1;
         end
         ST_CEL_RD: cmd.mem_rd = 1'b1;
         ST_CEL_WR: begin
            if (!(sts.op == OP_SET_OCCUPIED && sts.rd_blocked)) begin
               cmd.mem_wr  = 1'b1;
               cmd.wr_kind = WR_APPLY;
               cmd.ok_set  = 1'b1;
            end
         end
         ST_SWP_RD: begin
            cmd.mem_rd   = 1'b1;
            cmd.addr_sel = ADDR_SWEEP;
         end
         ST_SWP_WR: begin
            cmd.mem_wr   = 1'b1;
            cmd.addr_sel = ADDR_SWEEP;
            cmd.wr_kind  = WR_DROP_OCC;
            cmd.swp_step = 1'b1;
         end
         ST_CLR: begin
            cmd.mem_wr   = 1'b1;
            cmd.addr_sel = ADDR_SWEEP;
            cmd.swp_step = 1'b1;
         end
         ST_FIN_RD: cmd.mem_rd = 1'b1;
         ST_FIN_EV: cmd.capture = 1'b1;
         ST_RESP:   cmd.rsp_load = sts.rsp_free;
         default:   cmd.load = 1'b0;
      endcase
   end

   `CHECK_ALWAYS(a_no_rd_wr_same_cycle, clock, !(cmd.mem_rd && cmd.mem_wr))
   `CHECK_PROP(a_eval_follows_read, clock, reset, (state_ff == ST_CHK_EV) |-> ($past(state_ff) == ST_CHK_RD))
   `CHECK_PROP(a_rsp_load_free, clock, reset, cmd.rsp_load |-> sts.rsp_free)

endmodule

FILE: src/grid_footprint_occupancy.sv
// Top level of the grid occupancy block: joins the controller and the datapath.
// Depends on gfo_pkg, gfo_controller and gfo_datapath.
//
// A request walks its cells, then reads the start cell and responds. Each cell
// tested is read and checked and each cell marked is read and written, as the
// single-port cell store does one read or one write a cycle. Single-cell ops read
// one cell and may write it, query reads only the start cell and clear_placements
// sweeps the whole store. After reset and after a write of grid_cols or grid_rows
// while idle the store is cleared and no request is taken. A finished response
// waits in its own register, so the next request may be taken while it is stalled.
module grid_footprint_occupancy
   import gfo_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [OP_W-1:0]  req_op,
   input  logic [COL_W-1:0] req_start_col,
   input  logic [ROW_W-1:0] req_start_row,
   input  logic [DIM_W-1:0] req_span_cols,
   input  logic [DIM_W-1:0] req_span_rows,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic             rsp_ok,
   output logic             rsp_cell_blocked,
   output logic             rsp_cell_occupied,
   output logic             rsp_cell_available,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [DIM_W-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type sts;

   gfo_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .csr_we    (csr_we),
      .sts       (sts),
      .cmd       (cmd)
   );

   gfo_datapath u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_op             (req_op),
      .req_start_col      (req_start_col),
      .req_start_row      (req_start_row),
      .req_span_cols      (req_span_cols),
      .req_span_rows      (req_span_rows),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_ok             (rsp_ok),
      .rsp_cell_blocked   (rsp_cell_blocked),
      .rsp_cell_occupied  (rsp_cell_occupied),
      .rsp_cell_available (rsp_cell_available)
   );

endmodule
